FILE: design/qtth_pkg.sv
// shared constants, types and the arctangent table of the quaternion heading pipeline
package qtth_pkg;

  localparam int CORDIC_STEPS   = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int ANG_TABLE_LEN  = 24;
  localparam int N_STEPS = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;

  localparam int QW       = 16;
  localparam int NUM_W    = 34;
  localparam int DEN_W    = (2 * QUAT_FRAC_BITS + 2 > 35) ? 2 * QUAT_FRAC_BITS + 2 : 35;
  localparam int MAG_W    = DEN_W;
  localparam int POS_W    = $clog2(MAG_W);
  localparam int NORM_MSB = 29;
  localparam int CW       = 33;
  localparam int ZW       = 32;
  localparam int A_W      = 30;
  localparam int ANG_W    = 32;
  localparam int HD_W     = 16;
  localparam int TS_W     = 18;

  localparam logic signed [DEN_W-1:0] DEN_ONE =
    {{(DEN_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);

  localparam logic [ANG_W-1:0] ANG_90  = 32'd589824000;
  localparam logic [ANG_W-1:0] ANG_180 = 32'd1179648000;
  localparam logic [ANG_W-1:0] ANG_360 = 32'd2359296000;
  localparam logic [ANG_W:0]   RND_HALF = 33'd32768;
  localparam logic [HD_W:0]    TURN_CD   = 17'd36000;
  localparam logic signed [TS_W-1:0] TURN_CD_S = 18'sd36000;

  typedef struct packed {
    logic                   nneg;
    logic                   dneg;
    logic                   zero;
    logic signed [QW-1:0]   decl;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_ang(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 32'sd294912000;
      1:  v = 32'sd174096719;
      2:  v = 32'sd91987925;
      3:  v = 32'sd46694507;
      4:  v = 32'sd23437865;
      5:  v = 32'sd11730358;
      6:  v = 32'sd5866610;
      7:  v = 32'sd2933484;
      8:  v = 32'sd1466765;
      9:  v = 32'sd733385;
      10: v = 32'sd366693;
      11: v = 32'sd183346;
      12: v = 32'sd91673;
      13: v = 32'sd45837;
      14: v = 32'sd22918;
      15: v = 32'sd11459;
      16: v = 32'sd5730;
      17: v = 32'sd2865;
      18: v = 32'sd1432;
      19: v = 32'sd716;
      20: v = 32'sd358;
      21: v = 32'sd179;
      22: v = 32'sd90;
      23: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/quaternion_to_true_heading_top.sv
// pipelined quaternion to magnetic and true heading converter
//
// input channel in_*: one quaternion (w, x, y, z, signed q1.14) and a declination in
// centidegrees per transaction, packed 16 bits each into in_tdata from the low end.
// output channel out_*: one transaction per input transaction, in order, carrying the
// magnetic and the true heading in centidegrees 0..35999.
// the yaw numerator and denominator are formed, scaled to a fixed range and fed
// through a vectoring cordic with one register stage per rotation step.
// the pipeline holds 8 + N_STEPS register stages (24 with 16 steps). when nothing
// stalls, one transaction per cycle is accepted and delivered; the rate is set by
// one cordic step per stage.
// each stage carries a valid bit and loads whenever it is empty or its successor
// moves, so bubbles close up while out_tready is low and in_tready only drops once
// every stage holds an item. a stall loses and repeats nothing.
// synchronous reset empties the pipeline; no configuration and no other state.
module quaternion_to_true_heading_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // quat_real, quat_i, quat_j, quat_k, declination
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // magnetic_heading, true_heading
);

  localparam int NS     = qtth_pkg::N_STEPS;
  localparam int S_PROD = 0;
  localparam int S_SUM  = 1;
  localparam int S_ABS  = 2;
  localparam int S_LZ   = 3;
  localparam int S_NORM = 4;
  localparam int S_C0   = 5;
  localparam int S_ANG  = S_C0 + NS;
  localparam int S_RND  = S_ANG + 1;
  localparam int S_OUT  = S_RND + 1;
  localparam int NSTG   = S_OUT + 1;

  // valid / ready chain
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = 0; k < NSTG - 1; k++) begin
      rdy[NSTG-2-k] = !vld_r[NSTG-2-k] || rdy[NSTG-1-k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready  = rdy[S_PROD];
  assign out_tvalid = vld_r[S_OUT];

  // input fields
  logic signed [qtth_pkg::QW-1:0] w_in, x_in, y_in, z_in, decl_in;
  assign w_in    = $signed(in_tdata[15:0]);
  assign x_in    = $signed(in_tdata[31:16]);
  assign y_in    = $signed(in_tdata[47:32]);
  assign z_in    = $signed(in_tdata[63:48]);
  assign decl_in = $signed(in_tdata[79:64]);

  // products
  logic signed [31:0] p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  logic signed [qtth_pkg::QW-1:0] decl0_r;

  always_ff @(posedge clk) begin
    if (rdy[S_PROD]) begin
      p_wz_r  <= w_in * z_in;
      p_xy_r  <= x_in * y_in;
      p_yy_r  <= y_in * y_in;
      p_zz_r  <= z_in * z_in;
      decl0_r <= decl_in;
    end
  end

  // numerator and denominator
  logic signed [qtth_pkg::NUM_W-1:0] num_nxt, num_r;
  logic signed [qtth_pkg::DEN_W-1:0] den_nxt, den_r;
  logic signed [qtth_pkg::QW-1:0]    decl1_r;

  assign num_nxt = (qtth_pkg::NUM_W'(p_wz_r) + qtth_pkg::NUM_W'(p_xy_r)) <<< 1;
  assign den_nxt = qtth_pkg::DEN_ONE -
                   ((qtth_pkg::DEN_W'(p_yy_r) + qtth_pkg::DEN_W'(p_zz_r)) <<< 1);

  always_ff @(posedge clk) begin
    if (rdy[S_SUM]) begin
      num_r   <= num_nxt;
      den_r   <= den_nxt;
      decl1_r <= decl0_r;
    end
  end

  // magnitudes and quadrant flags
  logic [qtth_pkg::MAG_W-1:0] an_nxt, ad_nxt, an_r, ad_r;
  qtth_pkg::side_t side_nxt, side2_r;

  always_comb begin
    an_nxt        = qtth_pkg::MAG_W'(num_r[qtth_pkg::NUM_W-1] ? -num_r : num_r);
    ad_nxt        = qtth_pkg::MAG_W'(den_r[qtth_pkg::DEN_W-1] ? -den_r : den_r);
    side_nxt.nneg = num_r[qtth_pkg::NUM_W-1];
    side_nxt.dneg = den_r[qtth_pkg::DEN_W-1];
    side_nxt.zero = (num_r == '0) && (den_r == '0);
    side_nxt.decl = decl1_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_ABS]) begin
      an_r    <= an_nxt;
      ad_r    <= ad_nxt;
      side2_r <= side_nxt;
    end
  end

  // leading one of the larger magnitude
  logic [qtth_pkg::MAG_W-1:0] mx;
  logic [qtth_pkg::POS_W-1:0] pos_nxt, pos_r;
  logic [qtth_pkg::MAG_W-1:0] an3_r, ad3_r;
  qtth_pkg::side_t side3_r;

  always_comb begin
    mx      = (ad_r > an_r) ? ad_r : an_r;
    pos_nxt = '0;
    for (int j = 0; j < qtth_pkg::MAG_W; j++) begin
      if (mx[j]) begin
        pos_nxt = qtth_pkg::POS_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_LZ]) begin
      pos_r   <= pos_nxt;
      an3_r   <= an_r;
      ad3_r   <= ad_r;
      side3_r <= side2_r;
    end
  end

  // normalize and cordic stages
  logic [qtth_pkg::MAG_W-1:0] xs, ys;
  logic signed [qtth_pkg::CW-1:0] cx_r [NS+1];
  logic signed [qtth_pkg::CW-1:0] cy_r [NS+1];
  logic signed [qtth_pkg::ZW-1:0] cz_r [NS+1];
  qtth_pkg::side_t                cs_r [NS+1];

  always_comb begin
    if (pos_r > qtth_pkg::POS_W'(qtth_pkg::NORM_MSB)) begin
      xs = ad3_r >> (pos_r - qtth_pkg::POS_W'(qtth_pkg::NORM_MSB));
      ys = an3_r >> (pos_r - qtth_pkg::POS_W'(qtth_pkg::NORM_MSB));
    end else begin
      xs = ad3_r << (qtth_pkg::POS_W'(qtth_pkg::NORM_MSB) - pos_r);
      ys = an3_r << (qtth_pkg::POS_W'(qtth_pkg::NORM_MSB) - pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_NORM]) begin
      cx_r[0] <= $signed({{(qtth_pkg::CW-qtth_pkg::NORM_MSB-1){1'b0}},
                          xs[qtth_pkg::NORM_MSB:0]});
      cy_r[0] <= $signed({{(qtth_pkg::CW-qtth_pkg::NORM_MSB-1){1'b0}},
                          ys[qtth_pkg::NORM_MSB:0]});
      cz_r[0] <= '0;
      cs_r[0] <= side3_r;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic signed [qtth_pkg::ZW-1:0] ATAN_I = qtth_pkg::atan_ang(i);
    logic signed [qtth_pkg::CW-1:0] xsh, ysh;

    assign xsh = cx_r[i] >>> i;
    assign ysh = cy_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (rdy[S_C0+i]) begin
        if (!cy_r[i][qtth_pkg::CW-1]) begin
          cx_r[i+1] <= cx_r[i] + ysh;
          cy_r[i+1] <= cy_r[i] - xsh;
          cz_r[i+1] <= cz_r[i] + ATAN_I;
        end else begin
          cx_r[i+1] <= cx_r[i] - ysh;
          cy_r[i+1] <= cy_r[i] + xsh;
          cz_r[i+1] <= cz_r[i] - ATAN_I;
        end
        cs_r[i+1] <= cs_r[i];
      end
    end
  end

  // clamp and place in the full turn
  logic [qtth_pkg::A_W-1:0]   a_q;
  logic [qtth_pkg::ANG_W-1:0] ang_nxt, ang_r;
  qtth_pkg::side_t            ang_side_r;

  always_comb begin
    if (cs_r[NS].zero || cz_r[NS][qtth_pkg::ZW-1]) begin
      a_q = '0;
    end else if ($unsigned(cz_r[NS]) > qtth_pkg::ZW'(qtth_pkg::ANG_90)) begin
      a_q = qtth_pkg::ANG_90[qtth_pkg::A_W-1:0];
    end else begin
      a_q = cz_r[NS][qtth_pkg::A_W-1:0];
    end
    case ({cs_r[NS].dneg, cs_r[NS].nneg})
      2'b00:   ang_nxt = qtth_pkg::ANG_W'(a_q);
      2'b01:   ang_nxt = qtth_pkg::ANG_360 - qtth_pkg::ANG_W'(a_q);
      2'b10:   ang_nxt = qtth_pkg::ANG_180 - qtth_pkg::ANG_W'(a_q);
      default: ang_nxt = qtth_pkg::ANG_180 + qtth_pkg::ANG_W'(a_q);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[S_ANG]) begin
      ang_r      <= ang_nxt;
      ang_side_r <= cs_r[NS];
    end
  end

  // round to centidegrees
  logic [qtth_pkg::ANG_W:0]  rnd;
  logic [qtth_pkg::HD_W:0]   cdq;
  logic [qtth_pkg::HD_W-1:0] mag_nxt, mag_r;
  logic signed [qtth_pkg::QW-1:0] decl6_r;

  always_comb begin
    rnd = {1'b0, ang_r} + qtth_pkg::RND_HALF;
    cdq = rnd[qtth_pkg::ANG_W:16];
    if (cdq >= qtth_pkg::TURN_CD) begin
      mag_nxt = qtth_pkg::HD_W'(cdq - qtth_pkg::TURN_CD);
    end else begin
      mag_nxt = cdq[qtth_pkg::HD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_RND]) begin
      mag_r   <= mag_nxt;
      decl6_r <= ang_side_r.decl;
    end
  end

  // declination and wrap
  logic signed [qtth_pkg::TS_W-1:0] tsum, twrap;
  logic [qtth_pkg::HD_W-1:0] mag_out_r, tru_out_r;

  always_comb begin
    tsum = $signed({2'b00, mag_r}) + qtth_pkg::TS_W'(decl6_r);
    if (tsum >= qtth_pkg::TURN_CD_S) begin
      twrap = tsum - qtth_pkg::TURN_CD_S;
    end else if (tsum < 0) begin
      twrap = tsum + qtth_pkg::TURN_CD_S;
    end else begin
      twrap = tsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      mag_out_r <= mag_r;
      tru_out_r <= twrap[qtth_pkg::HD_W-1:0];
    end
  end

  assign out_tdata = {tru_out_r, mag_out_r};

  // checks
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] < 16'd36000) && (out_tdata[31:16] < 16'd36000))
    else $error("heading out of range");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without an output stall");

  a_bubble_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld_r) |-> in_tready)
    else $error("input stalled with an empty stage");

  a_angle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_ANG] |-> ang_r <= qtth_pkg::ANG_360)
    else $error("angle beyond a full turn");

  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_ANG] && ang_side_r.zero |-> ang_r == '0)
    else $error("zero vector gave a nonzero angle");

endmodule

FILE: tb/quaternion_to_true_heading_top_tb.sv
// self-checking testbench for the quaternion to magnetic and true heading pipeline
`timescale 1ns / 1ps

module quaternion_to_true_heading_top_tb;

  localparam int STEPS       = 16;
  localparam int TAB_LEN     = 24;
  localparam int HOLD_CYCLES = 90;
  localparam int DRAIN_WAIT  = 40;
  localparam longint ANGLE_90 = 64'sd589824000;
  localparam longint TURN     = 64'sd36000;

  typedef struct packed {
    logic signed [15:0] declination;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_real;
  } quat_t;

  typedef struct packed {
    logic [15:0] true_heading;
    logic [15:0] magnetic_heading;
  } heading_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // quat_real, quat_i, quat_j, quat_k, declination
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // magnetic_heading, true_heading

  heading_t expected_headings[$];
  heading_t oldest;
  longint   atan_cd [TAB_LEN] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466765, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  int errors;
  int sent;
  int checked;
  int stall_cycles;
  bit tx_free;
  bit rx_free;
  bit hold_req;

  quaternion_to_true_heading_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // first-quadrant angle of (ax, ay) in 1/65536 centidegree
  function automatic longint quadrant_angle(longint unsigned ax, longint unsigned ay);
    longint unsigned m;
    longint cx, cy, acc, nx;
    int i;
    m = (ax > ay) ? ax : ay;
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin
      ax = ax >> 1;
      ay = ay >> 1;
      m  = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      ax = ax << 1;
      ay = ay << 1;
      m  = m << 1;
    end
    cx  = longint'(ax);
    cy  = longint'(ay);
    acc = 0;
    for (i = 0; i < STEPS && i < TAB_LEN; i++) begin
      if (cy >= 0) begin
        nx  = cx + (cy >>> i);
        cy  = cy - (cx >>> i);
        acc = acc + atan_cd[i];
      end else begin
        nx  = cx - (cy >>> i);
        cy  = cy + (cx >>> i);
        acc = acc - atan_cd[i];
      end
      cx = nx;
    end
    if (acc < 0) acc = 0;
    if (acc > ANGLE_90) acc = ANGLE_90;
    return acc;
  endfunction

  function automatic heading_t predict_headings(quat_t q);
    longint w, x, y, z, decl, num, den, a, ang, mag, tru;
    longint unsigned an, ad;
    heading_t h;
    w    = q.quat_real;
    x    = q.quat_i;
    y    = q.quat_j;
    z    = q.quat_k;
    decl = q.declination;
    num  = 2 * (w * z + x * y);
    den  = (64'sd1 <<< 28) - 2 * (y * y + z * z);
    an   = (num < 0) ? longint'(-num) : longint'(num);
    ad   = (den < 0) ? longint'(-den) : longint'(den);
    a    = quadrant_angle(ad, an);
    if (den >= 0) ang = (num >= 0) ? a : 4 * ANGLE_90 - a;
    else          ang = (num >= 0) ? 2 * ANGLE_90 - a : 2 * ANGLE_90 + a;
    mag = (ang + 32768) / 65536;
    if (mag >= TURN) mag = mag - TURN;
    tru = mag + decl;
    while (tru >= TURN) tru = tru - TURN;
    while (tru < 0) tru = tru + TURN;
    h.magnetic_heading = 16'(mag);
    h.true_heading     = 16'(tru);
    return h;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [15:0] pick(int lo, int hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic send_quat(int w, int x, int y, int z, int decl);
    quat_t q;
    int gap;
    q.quat_real   = 16'(w);
    q.quat_i      = 16'(x);
    q.quat_j      = 16'(y);
    q.quat_k      = 16'(z);
    q.declination = 16'(decl);
    gap = tx_free ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    expected_headings.push_back(predict_headings(q));
    sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic test_directed();
    send_quat(16384, 0, 0, 0, 0);
    // zero vector: numerator and denominator both zero
    send_quat(0, 0, 8192, 8192, 1234);
    // negative x axis
    send_quat(0, 0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384, -18000);
    // full turn rounds back to zero
    send_quat(1, 0, 0, -1, 0);
    send_quat(16384, 0, 0, -1, 0);
    send_quat(0, 0, 0, 0, -18000);
    send_quat(11585, 0, 0, 11585, 18000);
    send_quat(11585, 0, 0, -11585, -17999);
    send_quat(6270, 0, 0, 15137, 100);
    send_quat(6270, 0, 0, -15137, -100);
    send_quat(-16384, -16384, -16384, -16384, 17999);
    send_quat(16384, 16384, 16384, 16384, -17999);
    send_quat(16384, -16384, 16384, -16384, 36000);
    // field extremes and declination far out of range
    send_quat(-32768, -32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -32768, 32767, 32767);
    send_quat(32767, -32768, 32767, -32768, -32768);
    send_quat(0, 16384, 16384, 0, 32767);
    send_quat(0, -16384, 16384, 0, -32768);
    send_quat(-1, 0, 0, 1, 1);
  endtask

  task automatic test_random_unit_range(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0)
        send_quat(pick(-4, 4), pick(-4, 4), pick(-4, 4), pick(-4, 4), pick(-18000, 18000));
      else
        send_quat(pick(-16384, 16384), pick(-16384, 16384), pick(-16384, 16384),
                  pick(-16384, 16384), pick(-18000, 18000));
    end
  endtask

  task automatic test_random_full_range(int count);
    int n;
    for (n = 0; n < count; n++)
      send_quat($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_back_to_back(int count);
    tx_free = 1'b1;
    rx_free = 1'b1;
    test_random_unit_range(count);
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  task automatic test_backpressure(int count);
    tx_free  = 1'b1;
    hold_req = 1'b1;
    test_random_unit_range(count);
    tx_free  = 1'b0;
    wait (!hold_req);
  endtask

  initial begin : tx_side
    errors       = 0;
    sent         = 0;
    checked      = 0;
    stall_cycles = 0;
    tx_free      = 1'b0;
    rx_free      = 1'b0;
    hold_req     = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    rst_n        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_unit_range(500);
    test_random_full_range(350);
    test_back_to_back(150);
    test_backpressure(100);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d quaternions sent (directed, in-range, full-range, back-to-back, held off)",
             sent);
    $display("%0d headings checked, input held back for %0d cycles", checked, stall_cycles);
    if (errors == 0 && expected_headings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : rx_side
    int  stretch;
    bit  level;
    stretch    = 0;
    level      = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
        stretch  = 0;
      end else if (rx_free) begin
        out_tready <= 1'b1;
      end else begin
        if (stretch == 0) begin
          level   = ($urandom_range(0, 99) < 65);
          if (level) stretch = $urandom_range(1, 16);
          else stretch = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
        end
        out_tready <= level;
        stretch--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      checked++;
      if (expected_headings.size() == 0) begin
        $error("unexpected transaction: magnetic_heading %0d, true_heading %0d",
               out_tdata[15:0], out_tdata[31:16]);
        errors++;
      end else begin
        oldest = expected_headings.pop_front();
        if (out_tdata[15:0] !== oldest.magnetic_heading) begin
          $error("magnetic_heading: expected %0d, actual %0d",
                 oldest.magnetic_heading, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[31:16] !== oldest.true_heading) begin
          $error("true_heading: expected %0d, actual %0d",
                 oldest.true_heading, out_tdata[31:16]);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
